@@ rtl/fopt_pkg.sv @@
`default_nettype none

package fopt_pkg;

  // Default number of table entries.
  localparam int FOPT_DEPTH = 64;

  localparam int DOC_W = 16;
  localparam int CNT_W = 16;
  localparam int CMD_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_EDIT   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  // One stored entry: identifier in the upper half, count in the lower half.
  typedef struct packed {
    logic [DOC_W-1:0] doc;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/frequency_ordered_posting_table.sv @@
`default_nettype none

// Frequency-ordered posting table: up to TABLE_DEPTH (document, count) pairs
// held in one synchronous RAM with one read and one write port, kept in order
// of falling count by adds; an edit sets a count in place without reordering.
// Each item is one command (add, search, edit, delete) and gives exactly one
// result item. Only one item is in work at a time. The table is searched from
// the head, each entry with a RAM read and then a compare. An add on a present
// entry moves it forward until it reaches the head or a predecessor whose count
// is not lower stops it; a delete pulls every later entry one place forward to
// close the gap. The result may wait for the output to drain before the next
// item is taken. No clearing pass is needed after reset: only entries below the
// fill count are ever read.
module frequency_ordered_posting_table
  import fopt_pkg::*;
#(
  parameter int TABLE_DEPTH = FOPT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] cmd, [17:2] doc_id, [33:18] new_count, [39:34] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] count, [16] found, [17] full_res, [23:18] zero
  output logic [23:0]      out_tdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TOT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [TOT_W-1:0] DEPTH_C = TOT_W'(TABLE_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SCAN_RD = 10'b0000000010,
    S_SCAN_CM = 10'b0000000100,
    S_ACT     = 10'b0000001000,
    S_BUB_RD  = 10'b0000010000,
    S_BUB_CM  = 10'b0000100000,
    S_FIN     = 10'b0001000000,
    S_SHF_RD  = 10'b0010000000,
    S_SHF_WR  = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [DOC_W-1:0] doc_r, doc_nxt;
  logic [CNT_W-1:0] nval_r, nval_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic             res_full_r, res_full_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             out_found_r, out_found_nxt;
  logic             out_full_r, out_full_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             addr_last;
  logic             pos_last;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_full_r, out_found_r, out_cnt_r};

  assign addr_last = ((TOT_W'(addr_r) + 1'b1) == total_r);
  assign pos_last  = ((TOT_W'(pos_r) + 1'b1) == total_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[addr_r];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    doc_nxt       = doc_r;
    nval_nxt      = nval_r;
    addr_nxt      = addr_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    res_cnt_nxt   = res_cnt_r;
    res_full_nxt  = res_full_r;
    total_nxt     = total_r;
    out_cnt_nxt   = out_cnt_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = '{doc: doc_r, cnt: cnt_r};

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = cmd_t'(in_tdata[1:0]);
          doc_nxt      = in_tdata[17:2];
          nval_nxt     = in_tdata[33:18];
          addr_nxt     = '0;
          hit_nxt      = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt    = (total_r == '0) ? S_ACT : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CM;
      end
      S_SCAN_CM: begin
        if (rdata_r.doc == doc_r) begin
          hit_nxt   = 1'b1;
          pos_nxt   = addr_r;
          cnt_nxt   = rdata_r.cnt;
          state_nxt = S_ACT;
        end else if (addr_last) begin
          state_nxt = S_ACT;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_ACT: begin
        state_nxt   = S_DONE;
        res_cnt_nxt = '0;
        case (cmd_r)
          CMD_ADD: begin
            if (hit_r) begin
              cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
              if (pos_r == '0) begin
                state_nxt = S_FIN;
              end else begin
                addr_nxt  = pos_r - 1'b1;
                state_nxt = S_BUB_RD;
              end
            end else if (total_r < DEPTH_C) begin
              wr_en       = 1'b1;
              wr_addr     = IDX_W'(total_r);
              wr_data     = '{doc: doc_r, cnt: CNT_W'(1)};
              total_nxt   = total_r + 1'b1;
              res_cnt_nxt = CNT_W'(1);
            end else begin
              res_full_nxt = 1'b1;
            end
          end
          CMD_SEARCH: begin
            if (hit_r) begin
              res_cnt_nxt = cnt_r;
            end
          end
          CMD_EDIT: begin
            if (hit_r) begin
              wr_en       = 1'b1;
              wr_data     = '{doc: doc_r, cnt: nval_r};
              res_cnt_nxt = nval_r;
            end
          end
          CMD_DELETE: begin
            if (hit_r) begin
              if (pos_last) begin
                total_nxt = total_r - 1'b1;
              end else begin
                addr_nxt  = pos_r + 1'b1;
                state_nxt = S_SHF_RD;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_BUB_RD: begin
        state_nxt = S_BUB_CM;
      end
      S_BUB_CM: begin
        // Move the predecessor back into the hole while the count beats it.
        if (cnt_r > rdata_r.cnt) begin
          wr_en   = 1'b1;
          wr_data = rdata_r;
          pos_nxt = addr_r;
          if (addr_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            addr_nxt  = addr_r - 1'b1;
            state_nxt = S_BUB_RD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        wr_en       = 1'b1;
        res_cnt_nxt = cnt_r;
        state_nxt   = S_DONE;
      end
      S_SHF_RD: begin
        state_nxt = S_SHF_WR;
      end
      S_SHF_WR: begin
        // Pull the next entry one place forward.
        wr_en   = 1'b1;
        wr_data = rdata_r;
        pos_nxt = addr_r;
        if (addr_last) begin
          total_nxt = total_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_SHF_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = res_cnt_r;
          out_found_nxt = hit_r;
          out_full_nxt  = res_full_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    doc_r       <= doc_nxt;
    nval_r      <= nval_nxt;
    addr_r      <= addr_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_full_r  <= res_full_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= DEPTH_C)
    else $error("fill count beyond table depth");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != $past(total_r)) |->
      (total_r == $past(total_r) + 1'b1 || total_r == $past(total_r) - 1'b1))
    else $error("fill count moved by more than one");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CM || state_r == S_IDLE) |-> !wr_en)
    else $error("table written during search");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken before result");

  a_full_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17]) |-> (out_tdata[16] == 1'b0 && out_tdata[15:0] == '0))
    else $error("full flag on a result that found or counted");
`endif

endmodule

`default_nettype wire

@@ tb/frequency_ordered_posting_table_test.sv @@
`timescale 1ns / 1ps

module frequency_ordered_posting_table_test;
  import fopt_pkg::*;

  localparam int DEPTH       = FOPT_DEPTH;
  localparam int POOL_SIZE   = 72;
  localparam int HOT_IDS     = 8;
  localparam int RANDOM_OPS  = 160;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic             found;
    logic             full_res;
  } posting_result_t;

  // Mirror of the posting table; works out each expected result item.
  class posting_scoreboard;
    logic [DOC_W-1:0] doc_tab[DEPTH];
    logic [CNT_W-1:0] cnt_tab[DEPTH];
    int               fill;
    posting_result_t  pending[$];
    int               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_input(cmd_t op, logic [DOC_W-1:0] doc, logic [CNT_W-1:0] nval);
      posting_result_t  res;
      int               pos;
      logic [DOC_W-1:0] td;
      logic [CNT_W-1:0] tc;
      pos = fill;
      for (int k = 0; k < fill; k++) begin
        if (doc_tab[k] == doc) begin
          pos = k;
          break;
        end
      end
      res.count    = '0;
      res.found    = (pos < fill);
      res.full_res = 1'b0;
      case (op)
        CMD_ADD: begin
          if (res.found) begin
            if (cnt_tab[pos] != CNT_MAX) cnt_tab[pos] = cnt_tab[pos] + 1'b1;
            // bubble forward while strictly ahead of the predecessor
            while (pos > 0 && cnt_tab[pos] > cnt_tab[pos-1]) begin
              td = doc_tab[pos];
              tc = cnt_tab[pos];
              doc_tab[pos]   = doc_tab[pos-1];
              cnt_tab[pos]   = cnt_tab[pos-1];
              doc_tab[pos-1] = td;
              cnt_tab[pos-1] = tc;
              pos--;
            end
            res.count = cnt_tab[pos];
          end else if (fill < DEPTH) begin
            doc_tab[fill] = doc;
            cnt_tab[fill] = 1;
            fill++;
            res.count = 1;
          end else begin
            res.full_res = 1'b1;
          end
        end
        CMD_SEARCH: begin
          if (res.found) res.count = cnt_tab[pos];
        end
        CMD_EDIT: begin
          if (res.found) begin
            cnt_tab[pos] = nval;
            res.count    = nval;
          end
        end
        default: begin
          if (res.found) begin
            for (int k = pos; k + 1 < fill; k++) begin
              doc_tab[k] = doc_tab[k+1];
              cnt_tab[k] = cnt_tab[k+1];
            end
            fill--;
          end
        end
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(logic [23:0] data);
      posting_result_t want;
      posting_result_t got;
      got.count    = data[15:0];
      got.found    = data[16];
      got.full_res = data[17];
      if (pending.size() == 0) begin
        $display("%0t: result item with none expected: count %0d found %0b full %0b",
                 $time, got.count, got.found, got.full_res);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.count != want.count) begin
        $display("%0t: count mismatch: expected %0d, actual %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.found != want.found) begin
        $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.full_res != want.full_res) begin
        $display("%0t: full_res mismatch: expected %0b, actual %0b",
                 $time, want.full_res, got.full_res);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  posting_scoreboard sb;
  logic [DOC_W-1:0]  doc_pool[POOL_SIZE];
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int                cycles;

  frequency_ordered_posting_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("frequency_ordered_posting_table_test: done, errors");
    $finish;
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(cmd_t op, logic [DOC_W-1:0] doc, logic [CNT_W-1:0] nval);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, nval, doc, op};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, doc, nval);
    @(negedge clk);
  endtask

  // Add every pool id once, so the table fills and later adds overflow.
  task automatic fill_table();
    int start;
    start = $urandom_range(0, POOL_SIZE - 1);
    for (int i = 0; i < POOL_SIZE; i++)
      send_op(CMD_ADD, doc_pool[(start + i) % POOL_SIZE], 16'($urandom));
  endtask

  task automatic random_ops(int n_ops);
    int               pick;
    int               sel;
    cmd_t             op;
    logic [DOC_W-1:0] doc;
    logic [CNT_W-1:0] nval;
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = CMD_ADD;
      else if (pick < 65) op = CMD_SEARCH;
      else if (pick < 80) op = CMD_EDIT;
      else                op = CMD_DELETE;
      sel = $urandom_range(0, 99);
      if (sel < 60)      doc = doc_pool[$urandom_range(0, HOT_IDS - 1)];
      else if (sel < 90) doc = doc_pool[$urandom_range(0, POOL_SIZE - 1)];
      else               doc = 16'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 40)      nval = 16'($urandom_range(0, 5));
      else if (sel < 60) nval = 16'($urandom_range(65530, 65535));
      else               nval = 16'($urandom);
      send_op(op, doc, nval);
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // starve the output so the block backs up into its input
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    hold_req  = 1'b0;
    doc_pool[0] = 16'h0000;
    doc_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) doc_pool[i] = 16'($urandom);
    send_idle_pct = 30;
    recv_idle_pct = 77;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: every lookup misses
    send_op(CMD_SEARCH, 16'h0000, 16'h0000);
    send_op(CMD_DELETE, 16'h0005, 16'h0000);
    send_op(CMD_EDIT,   16'h0007, 16'hFFFF);
    send_op(CMD_ADD,    16'h0000, 16'h0000);
    send_op(CMD_ADD,    16'hFFFF, 16'hFFFF);
    send_op(CMD_ADD,    16'h1234, 16'h0000);
    // second hit moves to the head
    send_op(CMD_ADD,    16'hFFFF, 16'h0000);
    send_op(CMD_SEARCH, 16'hFFFF, 16'h0000);
    // saturate at the maximum count
    send_op(CMD_EDIT,   16'h0000, 16'hFFFF);
    send_op(CMD_ADD,    16'h0000, 16'h0000);
    // lower an entry, then append behind it without reordering
    send_op(CMD_EDIT,   16'h1234, 16'h0000);
    send_op(CMD_ADD,    16'hABCD, 16'h0000);
    send_op(CMD_ADD,    16'h1234, 16'h0000);
    send_op(CMD_ADD,    16'h1234, 16'h0000);
    send_op(CMD_DELETE, 16'h0000, 16'h0000);
    send_op(CMD_DELETE, 16'hABCD, 16'h0000);
    send_op(CMD_EDIT,   16'hFFFF, 16'hAAAA);
    send_op(CMD_EDIT,   16'h1234, 16'h5555);
    send_op(CMD_SEARCH, 16'h1234, 16'h0000);
    send_op(CMD_DELETE, 16'h1234, 16'h0000);
    send_op(CMD_DELETE, 16'hFFFF, 16'h0000);
    fill_table();
    random_ops(RANDOM_OPS);

    send_idle_pct = 77;
    recv_idle_pct = 30;
    fill_table();
    random_ops(RANDOM_OPS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    fill_table();
    random_ops(RANDOM_OPS);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("frequency_ordered_posting_table_test: done, clean");
    end else begin
      $display("frequency_ordered_posting_table_test: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fopt_pkg.sv
rtl/frequency_ordered_posting_table.sv
tb/frequency_ordered_posting_table_test.sv
